// File: sv/mcc_pkg.sv
// ----------------------------------------------------------------------------
// mcc_pkg: shared types, codes and code tables of the Morse codec
// Holds the dot/dash table for A-Z and 0-9, the command format that the front
// end hands to the back end, and the action and command kind codes.
// ----------------------------------------------------------------------------
package mcc_pkg;

  localparam int SYM_COUNT   = 36;
  localparam int MAX_TOKEN   = 6;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  // input actions
  localparam logic [1:0] ACT_ENC = 2'd0;
  localparam logic [1:0] ACT_DEC = 2'd1;
  localparam logic [1:0] ACT_END = 2'd2;

  // command kinds
  localparam logic [1:0] KIND_CHAR  = 2'd0;  // one byte, last
  localparam logic [1:0] KIND_CODE  = 2'd1;  // dots/dashes then a space
  localparam logic [1:0] KIND_SLASH = 2'd2;  // slash then a space

  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_DASH  = 8'h2D;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_UA    = 8'h41;
  localparam logic [7:0] CH_UZ    = 8'h5A;
  localparam logic [7:0] CH_LA    = 8'h61;
  localparam logic [7:0] CH_LZ    = 8'h7A;
  localparam logic [7:0] CH_D0    = 8'h30;
  localparam logic [7:0] CH_D9    = 8'h39;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;

  typedef struct packed {
    logic [2:0] len;
    logic [4:0] pat;  // bit i set: symbol i is a dash
  } code_t;

  typedef struct packed {
    logic [1:0] kind;
    code_t      code;
    logic [7:0] ch;
  } mcc_cmd_t;

  function automatic code_t code_entry(input logic [5:0] idx);
    code_t c;
    unique case (idx)
      6'd0:  c = '{3'd2, 5'b00010};  // A
      6'd1:  c = '{3'd4, 5'b00001};  // B
      6'd2:  c = '{3'd4, 5'b00101};  // C
      6'd3:  c = '{3'd3, 5'b00001};  // D
      6'd4:  c = '{3'd1, 5'b00000};  // E
      6'd5:  c = '{3'd4, 5'b00100};  // F
      6'd6:  c = '{3'd3, 5'b00011};  // G
      6'd7:  c = '{3'd4, 5'b00000};  // H
      6'd8:  c = '{3'd2, 5'b00000};  // I
      6'd9:  c = '{3'd4, 5'b01110};  // J
      6'd10: c = '{3'd3, 5'b00101};  // K
      6'd11: c = '{3'd4, 5'b00010};  // L
      6'd12: c = '{3'd2, 5'b00011};  // M
      6'd13: c = '{3'd2, 5'b00001};  // N
      6'd14: c = '{3'd3, 5'b00111};  // O
      6'd15: c = '{3'd4, 5'b00110};  // P
      6'd16: c = '{3'd4, 5'b01011};  // Q
      6'd17: c = '{3'd3, 5'b00010};  // R
      6'd18: c = '{3'd3, 5'b00000};  // S
      6'd19: c = '{3'd1, 5'b00001};  // T
      6'd20: c = '{3'd3, 5'b00100};  // U
      6'd21: c = '{3'd4, 5'b01000};  // V
      6'd22: c = '{3'd3, 5'b00110};  // W
      6'd23: c = '{3'd4, 5'b01001};  // X
      6'd24: c = '{3'd4, 5'b01101};  // Y
      6'd25: c = '{3'd4, 5'b00011};  // Z
      6'd26: c = '{3'd5, 5'b11111};  // 0
      6'd27: c = '{3'd5, 5'b11110};  // 1
      6'd28: c = '{3'd5, 5'b11100};  // 2
      6'd29: c = '{3'd5, 5'b11000};  // 3
      6'd30: c = '{3'd5, 5'b10000};  // 4
      6'd31: c = '{3'd5, 5'b00000};  // 5
      6'd32: c = '{3'd5, 5'b00001};  // 6
      6'd33: c = '{3'd5, 5'b00011};  // 7
      6'd34: c = '{3'd5, 5'b00111};  // 8
      6'd35: c = '{3'd5, 5'b01111};  // 9
      default: c = '{3'd0, 5'b00000};
    endcase
    return c;
  endfunction

  function automatic logic [7:0] sym_char(input logic [5:0] idx);
    logic [7:0] r;
    if (idx < 6'd26) r = CH_UA + {2'b00, idx};
    else             r = CH_D0 + {2'b00, idx - 6'd26};
    return r;
  endfunction

endpackage

// File: sv/mcc_front.sv
// ----------------------------------------------------------------------------
// mcc_front: input side of the Morse codec
// Accepts items, looks up codes to encode, gathers decode tokens and pushes
// one command per producing item into the queue.
// ----------------------------------------------------------------------------
module mcc_front (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [1:0]       in_action,
  input  logic [7:0]       in_char_code,
  input  logic             q_full,
  output logic             q_push,
  output mcc_pkg::mcc_cmd_t q_cmd
);
  import mcc_pkg::*;

  logic [2:0] tok_len_r, tok_len_nxt;
  logic [4:0] tok_pat_r, tok_pat_nxt;
  logic       tok_other_r, tok_other_nxt;
  logic       tok_slash_r, tok_slash_nxt;

  logic       accept;
  logic [7:0] c_fold;
  logic       is_ws;
  logic       do_close;
  logic       found;
  logic [5:0] match_idx;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;
  assign c_fold   = (in_char_code >= CH_LA && in_char_code <= CH_LZ) ?
                    in_char_code - 8'd32 : in_char_code;
  assign is_ws    = (in_char_code == CH_SPACE) ||
                    (in_char_code >= CH_TAB && in_char_code <= CH_CR);
  assign do_close = (in_action == ACT_END) || (in_action == ACT_DEC && is_ws);

  // match the pending token against the whole table at once
  always_comb begin
    code_t e;
    found     = 1'b0;
    match_idx = '0;
    for (int i = 0; i < SYM_COUNT; i++) begin
      e = code_entry(6'(i));
      if (e.len == tok_len_r && e.pat == tok_pat_r) begin
        found     = 1'b1;
        match_idx = 6'(i);
      end
    end
  end

  always_comb begin
    tok_len_nxt   = tok_len_r;
    tok_pat_nxt   = tok_pat_r;
    tok_other_nxt = tok_other_r;
    tok_slash_nxt = tok_slash_r;
    q_push        = 1'b0;
    q_cmd         = '{kind: KIND_CHAR, code: '{3'd0, 5'd0}, ch: CH_SPACE};
    if (accept) begin
      if (in_action == ACT_ENC) begin
        if (c_fold >= CH_UA && c_fold <= CH_UZ) begin
          q_push     = 1'b1;
          q_cmd.kind = KIND_CODE;
          q_cmd.code = code_entry(6'(c_fold - CH_UA));
        end else if (c_fold >= CH_D0 && c_fold <= CH_D9) begin
          q_push     = 1'b1;
          q_cmd.kind = KIND_CODE;
          q_cmd.code = code_entry(6'(c_fold - CH_D0) + 6'd26);
        end else if (c_fold == CH_SPACE) begin
          q_push     = 1'b1;
          q_cmd.kind = KIND_SLASH;
        end
      end else if (do_close) begin
        if (!tok_other_r && tok_len_r != 3'd0) begin
          if (tok_slash_r) begin
            q_push = (tok_len_r == 3'd1);
          end else if (tok_len_r < 3'(MAX_TOKEN)) begin
            q_push   = found;
            q_cmd.ch = sym_char(match_idx);
          end
        end
        tok_len_nxt   = '0;
        tok_pat_nxt   = '0;
        tok_other_nxt = 1'b0;
        tok_slash_nxt = 1'b0;
      end else if (in_action == ACT_DEC) begin
        priority if (in_char_code == CH_SLASH) begin
          if (tok_len_r == 3'd0) tok_slash_nxt = 1'b1;
          else                   tok_other_nxt = 1'b1;
        end else if (in_char_code == CH_DASH) begin
          if (tok_len_r < 3'd5) tok_pat_nxt = tok_pat_r | (5'd1 << tok_len_r);
        end else if (in_char_code != CH_DOT) begin
          tok_other_nxt = 1'b1;
        end
        if (tok_len_r < 3'(MAX_TOKEN)) tok_len_nxt = tok_len_r + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_len_r   <= '0;
      tok_pat_r   <= '0;
      tok_other_r <= 1'b0;
      tok_slash_r <= 1'b0;
    end else begin
      tok_len_r   <= tok_len_nxt;
      tok_pat_r   <= tok_pat_nxt;
      tok_other_r <= tok_other_nxt;
      tok_slash_r <= tok_slash_nxt;
    end
  end

endmodule

// File: sv/mcc_queue.sv
// ----------------------------------------------------------------------------
// mcc_queue: command queue between front and back end
// Small first-in first-out buffer of commands; head is shown combinationally.
// ----------------------------------------------------------------------------
module mcc_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  mcc_pkg::mcc_cmd_t push_cmd,
  input  logic              pop,
  output mcc_pkg::mcc_cmd_t head_cmd,
  output logic              empty,
  output logic              full
);
  import mcc_pkg::*;

  mcc_cmd_t          slot_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QPTR_W:0]   count_r;

  assign empty    = (count_r == '0);
  assign full     = (count_r == (QPTR_W+1)'(QUEUE_DEPTH));
  assign head_cmd = slot_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) slot_r[wr_ptr_r] <= push_cmd;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + QPTR_W'(1);
      if (pop)  rd_ptr_r <= rd_ptr_r + QPTR_W'(1);
      if (push && !pop)      count_r <= count_r + (QPTR_W+1)'(1);
      else if (pop && !push) count_r <= count_r - (QPTR_W+1)'(1);
    end
  end

`ifndef SYNTHESIS
  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && full))
    else $error("queue overflow");
  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !(pop && empty))
    else $error("queue underflow");
  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |=> (count_r == $past(count_r) + (QPTR_W+1)'(1)))
    else $error("queue count lost a push");
`endif

endmodule

// File: sv/mcc_back.sv
// ----------------------------------------------------------------------------
// mcc_back: output side of the Morse codec
// Walks the head command one byte per cycle into the output register unless stalled.
// ----------------------------------------------------------------------------
module mcc_back (
  input  logic              clk,
  input  logic              rst_n,
  input  mcc_pkg::mcc_cmd_t head_cmd,
  input  logic              q_empty,
  output logic              q_pop,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [7:0]        out_char,
  output logic              out_last
);
  import mcc_pkg::*;

  logic [2:0] pos_r;
  logic       out_valid_r;
  logic [7:0] out_char_r, out_char_nxt;
  logic       out_last_r, out_last_nxt;
  logic       load;
  logic [7:0] pat_ext;

  assign out_valid = out_valid_r;
  assign out_char  = out_char_r;
  assign out_last  = out_last_r;

  assign load    = !q_empty && (!out_valid_r || !out_stall);
  assign q_pop   = load && out_last_nxt;
  assign pat_ext = {3'b000, head_cmd.code.pat};

  always_comb begin
    out_char_nxt = CH_SPACE;
    out_last_nxt = 1'b1;
    unique case (head_cmd.kind)
      KIND_CHAR: begin
        out_char_nxt = head_cmd.ch;
      end
      KIND_SLASH: begin
        if (pos_r == 3'd0) begin
          out_char_nxt = CH_SLASH;
          out_last_nxt = 1'b0;
        end
      end
      KIND_CODE: begin
        if (pos_r < head_cmd.code.len) begin
          out_char_nxt = pat_ext[pos_r] ? CH_DASH : CH_DOT;
          out_last_nxt = 1'b0;
        end
      end
      default: begin
        out_char_nxt = CH_SPACE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_char_r <= out_char_nxt;
      out_last_r <= out_last_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (load) begin
        out_valid_r <= 1'b1;
        pos_r       <= out_last_nxt ? 3'd0 : pos_r + 3'd1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

`ifndef SYNTHESIS
  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r <= 3'd5)
    else $error("symbol position out of range");
  a_char_first: assert property (@(posedge clk) disable iff (!rst_n)
    (!q_empty && head_cmd.kind == KIND_CHAR) |-> (pos_r == 3'd0))
    else $error("single byte command seen mid-sequence");
`endif

endmodule

// File: sv/morse_code_codec_top.sv
// ----------------------------------------------------------------------------
// morse_code_codec_top: Morse code encoder and decoder over ASCII bytes
// Encodes A-Z, a-z and 0-9 into dot/dash text and space into a slash, each with
// a trailing space, and decodes whitespace-separated dot/dash tokens into characters.
//
//   channel | ports                                  | direction
//   --------+----------------------------------------+-----------
//   input   | in_valid, in_stall, in_action,         | into block
//           | in_char_code                           |
//   result  | out_valid, out_stall, out_char,        | out of block
//           | out_last                               |
//
// Rate: one input transfer per cycle while the command queue has room; an
//   encoded character yields two to six result bytes, one per cycle while
//   out_stall is low, so the back end sets the sustained rate.
// Path: an accepted item is first registered in the queue; the output
//   register then loads the first result byte from the queue head unless
//   out_stall holds it.
// Reset: clears the pending decode token, empties the queue, drops out_valid.
// Stalls: in_stall rises only when the four-entry queue is full; out_stall
//   holds the output register and the walk through the head command.
// ----------------------------------------------------------------------------
module morse_code_codec_top (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] in_action,
  input  logic [7:0] in_char_code,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_char,
  output logic       out_last
);
  import mcc_pkg::*;

  logic     q_push, q_pop, q_empty, q_full;
  mcc_cmd_t push_cmd, head_cmd;

  // front end: classify items, gather decode tokens, push commands
  mcc_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_action    (in_action),
    .in_char_code (in_char_code),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_cmd        (push_cmd)
  );

  // decouple the two sides so that each can stall on its own
  mcc_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (push_cmd),
    .pop      (q_pop),
    .head_cmd (head_cmd),
    .empty    (q_empty),
    .full     (q_full)
  );

  // back end: advance through the head command one byte per transfer
  mcc_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head_cmd  (head_cmd),
    .q_empty   (q_empty),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_char  (out_char),
    .out_last  (out_last)
  );

endmodule
